FILE: hw/rtl/abkf_pkg.sv
// Package for the angle/bias Kalman filter core: widths, constants, opcodes and helpers.
// No dependencies.
package abkf_pkg;

  localparam int unsigned FracBits    = 24;
  localparam logic signed [31:0] OneQ24     = 32'sd16777216;
  localparam logic signed [31:0] AngleLimit = 32'sd23592960;
  localparam logic signed [31:0] BiasLimit  = 32'sd131072000;

  localparam logic [30:0] AngleNoiseRst   = 31'd16777;
  localparam logic [30:0] BiasNoiseRst    = 31'd50332;
  localparam logic [30:0] MeasureNoiseRst = 31'd8388608;
  localparam logic [24:0] SamplePeriodRst = 25'd167772;

  localparam logic [1:0] CfgAngleNoise   = 2'd0;
  localparam logic [1:0] CfgBiasNoise    = 2'd1;
  localparam logic [1:0] CfgMeasureNoise = 2'd2;
  localparam logic [1:0] CfgSamplePeriod = 2'd3;

  // Register file addresses of the datapath
  typedef enum logic [3:0] {
    R_ANG, R_BIAS, R_P00, R_P01, R_P10, R_P11, R_RATE, R_T,
    R_K0, R_K1, R_Y, R_MEAS, R_DT, R_QA, R_QB, R_ZERO
  } reg_sel_t;

  // ALU operations
  typedef enum logic [2:0] {
    OP_MUL,   // dst = qmul(a, b)
    OP_ADD,   // dst = sat(a + b)
    OP_SUB,   // dst = sat(a - b)
    OP_MOV,   // dst = a
    OP_DIV0,  // start gain division of a by S
    OP_DIV1,
    OP_NOP,
    OP_PSUM   // dst = sat(a - P01 - P10 + QA), saturated once
  } alu_op_t;

  typedef struct packed {
    logic      valid;
    alu_op_t   op;
    reg_sel_t  dst;
    reg_sel_t  src_a;
    reg_sel_t  src_b;
    logic      load;   // latch inputs and config into registers
  } cmd_t;

  typedef struct packed {
    logic busy;        // multi-cycle unit still running
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: hw/rtl/angle_bias_kalman_filter_core.sv
// Two-state Kalman filter (angle, gyro bias): one request in, one result out. An item is
// taken only when idle. The 27 micro-ops are issued in turn; each waits for its unit (ALU,
// shared multiplier or divider) before the program advances. Each of the two gain
// divisions runs issue, the 56-step restoring divider, write-back and advance. When the
// innovation variance is non-positive both divisions are skipped. Output stalls hold the
// filter in its output state; in_tready is low until the result has been taken.
// Depends on abkf_pkg, abkf_ctrl, abkf_datapath.
module angle_bias_kalman_filter_core import abkf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // angle_meas[24:0], rate_meas[52:25]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // angle_est[25:0], bias_est[53:26]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  logic [30:0] angle_noise_r, bias_noise_r, measure_noise_r;
  logic [24:0] sample_period_r;
  cmd_t cmd;
  sts_t sts;
  logic in_fire;
  logic signed [25:0] angle_est;
  logic signed [27:0] bias_est;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_noise_r   <= AngleNoiseRst;
      bias_noise_r    <= BiasNoiseRst;
      measure_noise_r <= MeasureNoiseRst;
      sample_period_r <= SamplePeriodRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgAngleNoise:   angle_noise_r   <= cfg_wdata;
        CfgBiasNoise:    bias_noise_r    <= cfg_wdata;
        CfgMeasureNoise: measure_noise_r <= cfg_wdata;
        CfgSamplePeriod: sample_period_r <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  abkf_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_ready(in_tready), .out_ready(out_tready),
    .out_valid(out_tvalid), .cmd, .sts
  );

  abkf_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .angle_meas(in_tdata[24:0]), .rate_meas(in_tdata[52:25]),
    .angle_noise(angle_noise_r), .bias_noise(bias_noise_r),
    .measure_noise(measure_noise_r), .sample_period(sample_period_r),
    .angle_est, .bias_est
  );

  assign out_tdata = {2'b00, bias_est, angle_est};

endmodule

FILE: hw/rtl/abkf_datapath.sv
// Datapath: register file, shared multiplier (two-stage) and serial divider.
// Depends on abkf_pkg.
module abkf_datapath import abkf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic signed [24:0]  angle_meas,
  input  logic signed [27:0]  rate_meas,
  input  logic [30:0]         angle_noise,
  input  logic [30:0]         bias_noise,
  input  logic [30:0]         measure_noise,
  input  logic [24:0]         sample_period,
  output logic signed [25:0]  angle_est,
  output logic signed [27:0]  bias_est
);

  logic signed [31:0] rf_r [15];
  logic signed [31:0] a_v, b_v, res;
  logic               wr;
  logic signed [34:0] psum;

  // multiply pipeline
  logic signed [63:0] prod_r;
  logic [1:0]         mul_cnt_r;
  reg_sel_t           mul_dst_r;

  // divider
  logic [5:0]         div_cnt_r;
  logic               div_run_r;
  logic               div_neg_r;
  logic [63:0]        rem_r;
  logic [63:0]        quo_r;
  logic [32:0]        den_r;
  logic [32:0]        s_w;
  reg_sel_t           div_dst_r;
  logic [64:0]        trial;
  logic signed [63:0] q_s;
  logic signed [63:0] rnd;
  logic signed [39:0] qm;
  logic               fin_r;

  assign a_v = (cmd.src_a == R_ZERO) ? 32'sd0 : rf_r[cmd.src_a];
  assign b_v = (cmd.src_b == R_ZERO) ? 32'sd0 : rf_r[cmd.src_b];
  assign s_w = {rf_r[R_P00][31], rf_r[R_P00]} + {2'b00, measure_noise};
  // predicted P00 term: one wide sum, saturated at the end
  assign psum = 35'(a_v) - 35'(rf_r[R_P01]) - 35'(rf_r[R_P10]) + 35'(rf_r[R_QA]);

  always_comb begin
    wr  = 1'b0;
    res = a_v;
    case (cmd.op)
      OP_ADD:  begin wr = cmd.valid; res = sat32(34'(a_v) + 34'(b_v)); end
      OP_SUB:  begin wr = cmd.valid; res = sat32(34'(a_v) - 34'(b_v)); end
      OP_MOV:  begin wr = cmd.valid; res = a_v; end
      OP_PSUM: begin
        wr = cmd.valid;
        if (psum > 35'sd2147483647)       res = 32'sh7fffffff;
        else if (psum < -35'sd2147483648) res = 32'sh80000000;
        else                              res = psum[31:0];
      end
      default: begin wr = 1'b0; res = a_v; end
    endcase
  end

  assign rnd   = prod_r + 64'sd8388608;
  assign qm    = rnd[63:24];
  assign trial = {1'b0, rem_r[62:0], quo_r[63]} - {32'd0, den_r};
  assign q_s   = div_neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
      div_run_r <= 1'b0;
      div_cnt_r <= '0;
      fin_r     <= 1'b0;
      rf_r[R_ANG]  <= '0;
      rf_r[R_BIAS] <= '0;
      rf_r[R_P00]  <= OneQ24;
      rf_r[R_P01]  <= '0;
      rf_r[R_P10]  <= '0;
      rf_r[R_P11]  <= OneQ24;
    end else begin
      if (cmd.load) begin
        rf_r[R_MEAS] <= 32'(angle_meas);
        rf_r[R_RATE] <= 32'(rate_meas);
        rf_r[R_DT]   <= {7'd0, sample_period};
        rf_r[R_QA]   <= {1'b0, angle_noise};
        rf_r[R_QB]   <= {1'b0, bias_noise};
      end
      if (wr) rf_r[cmd.dst] <= res;
      // multiplier: stage 1 product, stage 2 round and saturate
      if (cmd.valid && cmd.op == OP_MUL) begin
        prod_r    <= 64'(a_v) * 64'(b_v);
        mul_dst_r <= cmd.dst;
        mul_cnt_r <= 2'd1;
      end else if (mul_cnt_r == 2'd1) begin
        if (qm > 40'sd2147483647) rf_r[mul_dst_r] <= 32'sh7fffffff;
        else if (qm < -40'sd2147483648) rf_r[mul_dst_r] <= 32'sh80000000;
        else rf_r[mul_dst_r] <= qm[31:0];
        mul_cnt_r <= 2'd0;
      end
      // restoring divider, one quotient bit a cycle; dividend |a|*2^24 left-aligned
      if (cmd.valid && (cmd.op == OP_DIV0 || cmd.op == OP_DIV1)) begin
        div_dst_r <= cmd.dst;
        if ($signed(s_w) <= 33'sd0) begin
          rf_r[cmd.dst] <= '0;
        end else begin
          div_run_r <= 1'b1;
          div_cnt_r <= 6'd56;
          den_r     <= s_w;
          div_neg_r <= a_v[31];
          rem_r     <= '0;
          quo_r     <= {(a_v[31] ? 32'(-34'(a_v)) : a_v), 24'd0, 8'd0};
        end
      end else if (div_run_r) begin
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], quo_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) div_run_r <= 1'b0;
      end
      // divider result written in the cycle after the last step
      fin_r <= div_run_r && div_cnt_r == 6'd1;
      if (fin_r) begin
        if (q_s > 64'sd2147483647) rf_r[div_dst_r] <= 32'sh7fffffff;
        else if (q_s < -64'sd2147483648) rf_r[div_dst_r] <= 32'sh80000000;
        else rf_r[div_dst_r] <= q_s[31:0];
      end
    end
  end

  assign sts.busy = div_run_r || fin_r || mul_cnt_r != 2'd0;

  always_comb begin
    if (rf_r[R_ANG] > AngleLimit)       angle_est = AngleLimit[25:0];
    else if (rf_r[R_ANG] < -AngleLimit) angle_est = 26'(-AngleLimit);
    else                                angle_est = rf_r[R_ANG][25:0];
    if (rf_r[R_BIAS] > BiasLimit)       bias_est = BiasLimit[27:0];
    else if (rf_r[R_BIAS] < -BiasLimit) bias_est = 28'(-BiasLimit);
    else                                bias_est = rf_r[R_BIAS][27:0];
  end

endmodule

FILE: hw/rtl/abkf_ctrl.sv
// Controller: sequences the filter micro-program over the datapath, runs the handshake.
// Depends on abkf_pkg.
module abkf_ctrl import abkf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
  state_t   state_r;
  logic [4:0] pc_r;
  logic       issued_r;

  function automatic cmd_t prog(input logic [4:0] pc);
    cmd_t c;
    c = '{valid: 1'b1, op: OP_NOP, dst: R_ZERO, src_a: R_ZERO, src_b: R_ZERO,
          load: 1'b0};
    case (pc)
      5'd0:  begin c.op = OP_SUB; c.dst = R_RATE; c.src_a = R_RATE; c.src_b = R_BIAS; end
      5'd1:  begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_RATE; c.src_b = R_DT; end
      5'd2:  begin c.op = OP_ADD; c.dst = R_ANG; c.src_a = R_ANG; c.src_b = R_T; end
      5'd3:  begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_DT; c.src_b = R_P11; end
      5'd4:  begin c.op = OP_PSUM; c.dst = R_T; c.src_a = R_T; end
      5'd5:  begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_DT; c.src_b = R_T; end
      5'd6:  begin c.op = OP_ADD; c.dst = R_P00; c.src_a = R_P00; c.src_b = R_T; end
      5'd7:  begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_DT; c.src_b = R_P11; end
      5'd8:  begin c.op = OP_SUB; c.dst = R_P01; c.src_a = R_P01; c.src_b = R_T; end
      5'd9:  begin c.op = OP_SUB; c.dst = R_P10; c.src_a = R_P10; c.src_b = R_T; end
      5'd10: begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_QB; c.src_b = R_DT; end
      5'd11: begin c.op = OP_ADD; c.dst = R_P11; c.src_a = R_P11; c.src_b = R_T; end
      5'd12: begin c.op = OP_DIV0; c.dst = R_K0; c.src_a = R_P00; end
      5'd13: begin c.op = OP_DIV1; c.dst = R_K1; c.src_a = R_P10; end
      5'd14: begin c.op = OP_SUB; c.dst = R_Y; c.src_a = R_MEAS; c.src_b = R_ANG; end
      5'd15: begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_K0; c.src_b = R_Y; end
      5'd16: begin c.op = OP_ADD; c.dst = R_ANG; c.src_a = R_ANG; c.src_b = R_T; end
      5'd17: begin c.op = OP_MUL; c.dst = R_Y; c.src_a = R_K1; c.src_b = R_Y; end
      5'd18: begin c.op = OP_ADD; c.dst = R_BIAS; c.src_a = R_BIAS; c.src_b = R_Y; end
      // covariance correction from pre-update values; P01 after P11, P00 last (P11, P10 need them)
      5'd19: begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_K1; c.src_b = R_P00; end
      5'd20: begin c.op = OP_SUB; c.dst = R_P10; c.src_a = R_P10; c.src_b = R_T; end
      5'd21: begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_K1; c.src_b = R_P01; end
      5'd22: begin c.op = OP_SUB; c.dst = R_P11; c.src_a = R_P11; c.src_b = R_T; end
      5'd23: begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_K0; c.src_b = R_P01; end
      5'd24: begin c.op = OP_SUB; c.dst = R_P01; c.src_a = R_P01; c.src_b = R_T; end
      5'd25: begin c.op = OP_MUL; c.dst = R_T; c.src_a = R_K0; c.src_b = R_P00; end
      5'd26: begin c.op = OP_SUB; c.dst = R_P00; c.src_a = R_P00; c.src_b = R_T; end
      default: c.valid = 1'b0;
    endcase
    return c;
  endfunction

  localparam logic [4:0] LastPc = 5'd26;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd = prog(pc_r);
    cmd.valid = (state_r == S_RUN) && !sts.busy && !issued_r;
    cmd.load  = in_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      issued_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) begin state_r <= S_RUN; pc_r <= '0; issued_r <= 1'b0; end
        S_RUN: begin
          // issue one command, hold issued_r so busy becomes visible, then advance when not busy
          if (cmd.valid) issued_r <= 1'b1;
          else if (issued_r && !sts.busy) begin
            issued_r <= 1'b0;
            if (pc_r == LastPc) state_r <= S_OUT;
            else pc_r <= pc_r + 5'd1;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("load outside idle");
  a_no_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.valid |-> !sts.busy) else $error("command while unit busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: tb/sv/tb_angle_bias_kalman_filter_core.sv
// Testbench for angle_bias_kalman_filter_core: drives angle/rate requests, predicts the
// filtered angle and bias in a local fixed-point filter model and checks every result.
// Depends on abkf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_angle_bias_kalman_filter_core import abkf_pkg::*;;

  localparam int WatchdogLimit = 20000;
  localparam int HoldCycles = 600;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;    // angle_meas[24:0], rate_meas[52:25]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // angle_est[25:0], bias_est[53:26]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_wdata;

  angle_bias_kalman_filter_core uut (.*);

  typedef struct packed {
    logic signed [27:0] rate_meas;
    logic signed [24:0] angle_meas;
  } sample_t;

  typedef struct packed {
    logic signed [27:0] bias_est;
    logic signed [25:0] angle_est;
  } estimate_t;

  // filter model state
  logic [30:0] m_qa, m_qb, m_r;
  logic [24:0] m_dt;
  longint      m_ang, m_bias;
  longint      m_p[4];

  sample_t   sample_q[$];
  estimate_t estimate_q[$];
  int        errors = 0;
  int        results = 0;
  int        accepted = 0;
  int        idle_cycles = 0;
  bit        hold_go = 0;
  bit        hold_done = 0;
  int        hold_cnt = 0;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product of two 32-bit values >> 24, rounded half up; fits in 64 bits
  function automatic longint fxmul(input longint a, input longint b);
    longint p;
    p = a * b + 64'sd8388608;
    return sat(p >>> 24);
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void filter_reset();
    m_qa = AngleNoiseRst; m_qb = BiasNoiseRst; m_r = MeasureNoiseRst;
    m_dt = SamplePeriodRst;
    m_ang = 0; m_bias = 0;
    m_p[0] = OneQ24; m_p[1] = 0; m_p[2] = 0; m_p[3] = OneQ24;
  endfunction

  function automatic estimate_t filter_step(input sample_t s);
    longint dt, p00, p01, p10, p11, t, rate, y, k0, k1, sv;
    estimate_t e;
    dt = m_dt;
    rate = sat(longint'(s.rate_meas) - m_bias);
    m_ang = sat(m_ang + fxmul(rate, dt));
    p00 = m_p[0]; p01 = m_p[1]; p10 = m_p[2]; p11 = m_p[3];
    t = sat(fxmul(dt, p11) - p01 - p10 + longint'(m_qa));
    p00 = sat(p00 + fxmul(dt, t));
    t = fxmul(dt, p11);
    p01 = sat(p01 - t);
    p10 = sat(p10 - t);
    p11 = sat(p11 + fxmul(longint'(m_qb), dt));
    sv = p00 + longint'(m_r);
    if (sv > 0) begin
      k0 = sat((p00 * 64'sd16777216) / sv);
      k1 = sat((p10 * 64'sd16777216) / sv);
    end else begin
      k0 = 0; k1 = 0;
    end
    y = sat(longint'(s.angle_meas) - m_ang);
    m_ang = sat(m_ang + fxmul(k0, y));
    m_bias = sat(m_bias + fxmul(k1, y));
    m_p[0] = sat(p00 - fxmul(k0, p00));
    m_p[1] = sat(p01 - fxmul(k0, p01));
    m_p[2] = sat(p10 - fxmul(k1, p00));
    m_p[3] = sat(p11 - fxmul(k1, p01));
    e.angle_est = 26'(clip(m_ang, AngleLimit));
    e.bias_est = 28'(clip(m_bias, BiasLimit));
    return e;
  endfunction

  function automatic void filter_step_push(input sample_t s);
    estimate_q.push_back(filter_step(s));
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        filter_step_push(sample_t'(in_tdata[52:0]));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 0;
        end else if (sample_q.size() > 0) begin
          in_tvalid <= 1;
          in_tdata <= {3'b000, sample_q.pop_front()};
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
          end
        end else
          in_tvalid <= 0;
      end
    end
  end

  // monitor / checker, receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        estimate_t got, exp_e;
        got = estimate_t'(out_tdata[53:0]);
        results++;
        if (estimate_q.size() == 0) begin
          $error("result with no request pending: %h", out_tdata);
          errors++;
        end else begin
          exp_e = estimate_q.pop_front();
          if (got.angle_est !== exp_e.angle_est) begin
            $error("angle_est expected %0d got %0d", exp_e.angle_est, got.angle_est);
            errors++;
          end
          if (got.bias_est !== exp_e.bias_est) begin
            $error("bias_est expected %0d got %0d", exp_e.bias_est, got.bias_est);
            errors++;
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_cnt = HoldCycles;
        hold_done = 1;
      end
      stall_phase = (stall_phase + 1) % 23;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 0;
      end else if (stall_phase < 6) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 2) != 0);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: %0d requests outstanding", estimate_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CfgAngleNoise:   m_qa = val;
      CfgBiasNoise:    m_qb = val;
      CfgMeasureNoise: m_r = val;
      default:         m_dt = val[24:0];
    endcase
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !in_tvalid && estimate_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(input int mode);
    sample_t s;
    if (mode == 0) begin
      s.angle_meas = $urandom_range(0, 23592960) - 11796480;
      s.rate_meas = $urandom_range(0, 262144000) - 131072000;
    end else begin
      // gentle signals so the estimate tracks
      s.angle_meas = $urandom_range(0, 1966080) - 983040;
      s.rate_meas = $urandom_range(0, 6553600) - 3276800;
    end
    return s;
  endfunction

  initial begin
    sample_t s;
    logic [30:0] big;
    rst_n = 0;
    cfg_we = 0; cfg_index = CfgAngleNoise; cfg_wdata = '0;
    filter_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed extremes at reset settings
    s = '{rate_meas: 131072000, angle_meas: 11796480};   sample_q.push_back(s);
    s = '{rate_meas: -131072000, angle_meas: -11796480}; sample_q.push_back(s);
    s = '{rate_meas: 0, angle_meas: 0};                  sample_q.push_back(s);
    s = '{rate_meas: 131072000, angle_meas: 11796480};   sample_q.push_back(s);
    s = '{rate_meas: 131072000, angle_meas: 11796480};   sample_q.push_back(s);
    s = '{rate_meas: -1, angle_meas: -1};                sample_q.push_back(s);
    drain();

    // zero measurement noise with converged covariance -> S may reach zero
    cfg_write(CfgMeasureNoise, 31'd0);
    cfg_write(CfgAngleNoise, 31'd0);
    cfg_write(CfgBiasNoise, 31'd0);
    cfg_write(CfgSamplePeriod, 25'd0);
    for (int i = 0; i < 6; i++) sample_q.push_back(rand_sample(0));
    drain();

    // maximum noise settings and a sample period of one drive the state into saturation
    cfg_write(CfgAngleNoise, 31'h7fffffff);
    cfg_write(CfgBiasNoise, 31'h7fffffff);
    cfg_write(CfgMeasureNoise, 31'h7fffffff);
    cfg_write(CfgSamplePeriod, 25'h1000000);
    for (int i = 0; i < 6; i++) sample_q.push_back(rand_sample(0));
    s = '{rate_meas: 28'sh8000000, angle_meas: 25'sh1000000}; sample_q.push_back(s);
    s = '{rate_meas: 28'sh7ffffff, angle_meas: 25'sh0ffffff}; sample_q.push_back(s);
    drain();

    cfg_write(CfgMeasureNoise, 31'd1);
    cfg_write(CfgSamplePeriod, 25'd1);
    cfg_write(CfgAngleNoise, 31'd16777);
    cfg_write(CfgBiasNoise, 31'd50332);
    for (int i = 0; i < 4; i++) sample_q.push_back(rand_sample(1));
    drain();

    // phases at reset settings, then random settings; full 25/28-bit codes cover every bit
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) begin
        cfg_write(CfgAngleNoise, AngleNoiseRst);
        cfg_write(CfgBiasNoise, BiasNoiseRst);
        cfg_write(CfgMeasureNoise, MeasureNoiseRst);
        cfg_write(CfgSamplePeriod, SamplePeriodRst);
      end else begin
        big = $urandom;
        cfg_write(CfgAngleNoise, (ph % 3 == 0) ? big : big >> $urandom_range(8, 30));
        big = $urandom;
        cfg_write(CfgBiasNoise, (ph % 3 == 1) ? big : big >> $urandom_range(8, 30));
        big = $urandom;
        cfg_write(CfgMeasureNoise, (big >> $urandom_range(0, 30)) | 31'd1);
        big = $urandom;
        cfg_write(CfgSamplePeriod, (big[24:0] >> $urandom_range(0, 24)) | 25'd1);
      end
      for (int i = 0; i < 145; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          s = sample_t'(53'({$urandom, $urandom}));
        end else
          s = rand_sample($urandom_range(0, 3) == 0 ? 0 : 1);
        sample_q.push_back(s);
      end
      if (ph == 3) begin
        // long receiver hold-off while the sender keeps offering
        wait (accepted > 0);
        hold_go = 1;
        wait (hold_done && hold_cnt == 0);
      end
      drain();
    end

    $display("Checked %0d results over %0d requests across reset, zero, extreme and random",
             results, accepted);
    $display("filter settings, with receiver hold-off and stalls on both sides.");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
